// ===== rtl/bpra_pkg.sv =====
// Shared types and constants of the bitmap page run allocator.
`default_nettype none

package bpra_pkg;

	localparam int CNT_W  = 17;
	localparam int RUN_W  = 18;
	localparam int WORD_W = 64;
	localparam int CHUNK  = 8;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	typedef struct packed {
		logic             found;
		logic [5:0]       hit_bit;
		logic [6:0]       next_off;
		logic [RUN_W-1:0] run_next;
	} scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/bpra_map_ram.sv =====
// Used-page map memory, one 64-page row per word.
`default_nettype none

module bpra_map_ram #(
	parameter int ROWS = 1024,
	parameter int RAW  = 10
) (
	input  wire                            clk,
	input  wire                            we,
	input  wire  [RAW-1:0]                 waddr,
	input  wire  [bpra_pkg::WORD_W-1:0]    wdata,
	input  wire                            re,
	input  wire  [RAW-1:0]                 raddr,
	output logic [bpra_pkg::WORD_W-1:0]    rdata
);

	logic [bpra_pkg::WORD_W-1:0] mem_q [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bpra_run_scan.sv =====
// Run search step over one chunk or one whole row of the used map.
`default_nettype none

module bpra_run_scan (
	input  wire  [bpra_pkg::WORD_W-1:0] word,
	input  wire  [5:0]                  cur_off,
	input  wire  [6:0]                  start_off,
	input  wire  [6:0]                  lim_off,
	input  wire  [bpra_pkg::RUN_W-1:0]  run,
	input  wire  [bpra_pkg::CNT_W-1:0]  need,
	output bpra_pkg::scan_res_t         res
);

	always_comb begin
		logic [bpra_pkg::RUN_W-1:0] r;
		logic                       hit;
		logic [5:0]                 hb;
		logic [5:0]                 j;
		logic                       fr;
		logic                       full_row;
		logic [6:0]                 nxt;
		r        = run;
		hit      = 1'b0;
		hb       = 6'd0;
		j        = 6'd0;
		fr       = 1'b0;
		full_row = (cur_off == 6'd0) && (start_off == 7'd0) && (lim_off == 7'd64);
		if (full_row && (word == {bpra_pkg::WORD_W{1'b1}})) begin
			r   = '0;
			nxt = 7'd64;
		end else if (full_row && (word == '0) &&
				((run + bpra_pkg::RUN_W'(64)) < bpra_pkg::RUN_W'(need))) begin
			r   = run + bpra_pkg::RUN_W'(64);
			nxt = 7'd64;
		end else begin
			for (int k = 0; k < bpra_pkg::CHUNK; k++) begin
				j  = {cur_off[5:3], 3'(k)};
				fr = !word[j] && ({1'b0, j} >= start_off) && ({1'b0, j} < lim_off);
				if (!hit) begin
					if (fr) begin
						r = r + bpra_pkg::RUN_W'(1);
					end else begin
						r = '0;
					end
					if (fr && (r == bpra_pkg::RUN_W'(need))) begin
						hit = 1'b1;
						hb  = j;
					end
				end
			end
			nxt = {1'b0, cur_off[5:3], 3'b000} + 7'd8;
		end
		res.found    = hit;
		res.hit_bit  = hb;
		res.next_off = nxt;
		res.run_next = r;
	end

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_run_allocator.sv =====
// Top level of the next-fit bitmap page run allocator.
//
// Requests enter on the s_axis group: tuser carries the command, tdata the
// first page and the page count. One result per request leaves on m_axis:
// tuser carries the status, tdata the first allocated page and the pages in
// use afterwards. The cfg channel writes the usable page limit; cfg_ready is
// always high.
// After reset the map is set to all used by a sweep, one map row a cycle;
// s_axis_tready stays low until it ends.
// One request at a time. An allocate searches the map with one shared search
// step: a fully used row that lies wholly in the pass (row zero apart), or a
// free row that cannot complete the run, takes one fetch and one step;
// otherwise a row takes one fetch and up to eight steps of eight pages. A
// search makes two passes at most. Marking and clearing read and then write
// each row; the map memory port sets the row rate.
// A finished result sits in the output register; a new request is taken
// while it waits, and the block holds a second result until m_axis_tready.
`default_nettype none

module bitmap_page_run_allocator #(
	parameter int PAGES = 65536
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [1:0]  s_axis_tuser,   // command
	input  wire  [39:0] s_axis_tdata,   // page_index, page_count, zero pad
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [1:0]  m_axis_tuser,   // status
	output logic [39:0] m_axis_tdata,   // first_page, pages_in_use, zero pad
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [16:0] cfg_data
);

	localparam int ROWS = (PAGES + 63) / 64;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int XW   = ($clog2(PAGES) + 2 > 18) ? $clog2(PAGES) + 2 : 18;
	localparam logic [XW-1:0] PAGES_X = XW'(PAGES);
	localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_RMW_RD,
		S_RMW_WR,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [1:0]                   cmd_q;
	logic [bpra_pkg::CNT_W-1:0]   n_q;
	logic [1:0]                   status_q;
	logic [15:0]                  first_q;
	logic [bpra_pkg::CNT_W-1:0]   count_q;
	logic [16:0]                  usable_q;
	logic [XW-1:0]                ptr_q;
	logic [XW-1:0]                cur_q;
	logic [XW-1:0]                start_q;
	logic [XW-1:0]                lim_pass_q;
	logic [bpra_pkg::RUN_W-1:0]   run_q;
	logic                         pass2_q;
	logic [XW-1:0]                lo_q;
	logic [XW-1:0]                hi_q;
	logic [RAW-1:0]               row_q;
	logic                         set_q;
	logic [RAW-1:0]               init_row_q;
	logic                         m_valid_q;
	logic [1:0]                   m_tuser_q;
	logic [39:0]                  m_tdata_q;

	logic [bpra_pkg::CNT_W-1:0]   in_count;
	logic [15:0]                  in_page;
	logic [XW-1:0]                page_x;
	logic [XW-1:0]                end_x;
	logic [XW-1:0]                clip_x;
	logic [XW-1:0]                lim;
	logic [XW-1:0]                row_base;
	logic [6:0]                   start_off;
	logic [6:0]                   lim_off;
	logic [XW-1:0]                cur_next;
	logic [XW-1:0]                found_pg;
	logic [XW-1:0]                found_lo;
	logic [bpra_pkg::CNT_W:0]     cnt_sum;
	logic [bpra_pkg::CNT_W-1:0]   cnt_add;
	logic [bpra_pkg::CNT_W-1:0]   cnt_sub;
	logic [bpra_pkg::WORD_W-1:0]  lo_mask;
	logic [bpra_pkg::WORD_W-1:0]  hi_mask;
	logic [bpra_pkg::WORD_W-1:0]  row_mask;
	logic                         mem_we;
	logic [RAW-1:0]               mem_waddr;
	logic [bpra_pkg::WORD_W-1:0]  mem_wdata;
	logic                         mem_re;
	logic [RAW-1:0]               mem_raddr;
	logic [bpra_pkg::WORD_W-1:0]  mem_rdata;
	bpra_pkg::scan_res_t          scan_res;
	logic                         in_fire;
	logic                         out_load;

	assign in_count = s_axis_tdata[32:16];
	assign in_page  = s_axis_tdata[15:0];
	assign page_x   = XW'(in_page);
	assign end_x    = page_x + XW'(in_count) - XW'(1);
	assign clip_x   = (end_x > PAGES_X - XW'(1)) ? PAGES_X - XW'(1) : end_x;
	assign lim      = (XW'(usable_q) < PAGES_X) ? XW'(usable_q) : PAGES_X;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tdata  = m_tdata_q;

	assign row_base = {cur_q[XW-1:6], 6'b000000};

	always_comb begin
		if (start_q[XW-1:6] == cur_q[XW-1:6]) begin
			start_off = {1'b0, start_q[5:0]};
		end else begin
			start_off = 7'd0;
		end
		if ((cur_q[XW-1:6] == '0) && (start_off == 7'd0)) begin
			start_off = 7'd1;
		end
		if (lim_pass_q[XW-1:6] == cur_q[XW-1:6]) begin
			lim_off = {1'b0, lim_pass_q[5:0]};
		end else begin
			lim_off = 7'd64;
		end
	end

	bpra_run_scan u_scan (
		.word      (mem_rdata),
		.cur_off   (cur_q[5:0]),
		.start_off (start_off),
		.lim_off   (lim_off),
		.run       (run_q),
		.need      (n_q),
		.res       (scan_res)
	);

	assign cur_next = row_base + XW'(scan_res.next_off);
	assign found_pg = row_base + XW'(scan_res.hit_bit);
	assign found_lo = found_pg + XW'(1) - XW'(n_q);

	assign cnt_sum = {1'b0, count_q} + {1'b0, n_q};
	assign cnt_add = (cnt_sum > {1'b0, bpra_pkg::CNT_MAX}) ? bpra_pkg::CNT_MAX
		: cnt_sum[bpra_pkg::CNT_W-1:0];
	assign cnt_sub = (count_q < in_count) ? '0 : count_q - in_count;

	assign lo_mask  = (row_q == lo_q[RAW+5:6]) ?
		({bpra_pkg::WORD_W{1'b1}} << lo_q[5:0]) : {bpra_pkg::WORD_W{1'b1}};
	assign hi_mask  = (row_q == hi_q[RAW+5:6]) ?
		({bpra_pkg::WORD_W{1'b1}} >> (6'd63 - hi_q[5:0])) : {bpra_pkg::WORD_W{1'b1}};
	assign row_mask = lo_mask & hi_mask;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = set_q ? (mem_rdata | row_mask) : (mem_rdata & ~row_mask);
		mem_re    = 1'b0;
		mem_raddr = row_q;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_row_q;
				mem_wdata = {bpra_pkg::WORD_W{1'b1}};
			end
			S_FETCH: begin
				mem_re    = (cur_q < lim_pass_q);
				mem_raddr = cur_q[RAW+5:6];
			end
			S_RMW_RD: begin
				mem_re = 1'b1;
			end
			S_RMW_WR: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	bpra_map_ram #(
		.ROWS (ROWS),
		.RAW  (RAW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			usable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_row_q <= '0;
			count_q    <= '0;
			ptr_q      <= '0;
			pass2_q    <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_row_q <= init_row_q + RAW'(1);
					if (init_row_q == LAST_ROW) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						cmd_q    <= s_axis_tuser;
						n_q      <= in_count;
						first_q  <= '0;
						lo_q     <= page_x;
						hi_q     <= clip_x;
						row_q    <= page_x[RAW+5:6];
						set_q    <= 1'b0;
						case (s_axis_tuser)
							bpra_pkg::CMD_ALLOC: begin
								if (in_count == '0) begin
									status_q <= bpra_pkg::ST_ZERO;
									state_q  <= S_DONE;
								end else begin
									status_q   <= bpra_pkg::ST_DONE;
									cur_q      <= ptr_q;
									start_q    <= ptr_q;
									run_q      <= '0;
									pass2_q    <= 1'b0;
									lim_pass_q <= lim;
									state_q    <= S_FETCH;
								end
							end
							bpra_pkg::CMD_FREE: begin
								status_q <= bpra_pkg::ST_DONE;
								if (in_page != '0) begin
									if (page_x < ptr_q) begin
										ptr_q <= page_x;
									end
									count_q <= cnt_sub;
								end
								state_q <= ((in_page != '0) && (in_count != '0) &&
									(page_x < PAGES_X)) ? S_RMW_RD : S_DONE;
							end
							bpra_pkg::CMD_RELEASE: begin
								status_q <= bpra_pkg::ST_DONE;
								state_q  <= ((in_count != '0) && (page_x < PAGES_X)) ?
									S_RMW_RD : S_DONE;
							end
							default: begin
								status_q <= bpra_pkg::ST_DONE;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_FETCH: begin
					if (cur_q >= lim_pass_q) begin
						if (!pass2_q) begin
							pass2_q    <= 1'b1;
							cur_q      <= '0;
							start_q    <= '0;
							run_q      <= '0;
							lim_pass_q <= (ptr_q < lim) ? ptr_q : lim;
						end else begin
							status_q <= bpra_pkg::ST_OOM;
							state_q  <= S_DONE;
						end
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_res.found) begin
						ptr_q   <= found_pg + XW'(1);
						count_q <= cnt_add;
						first_q <= found_lo[15:0];
						lo_q    <= found_lo;
						hi_q    <= found_pg;
						row_q   <= found_lo[RAW+5:6];
						set_q   <= 1'b1;
						state_q <= S_RMW_RD;
					end else begin
						cur_q <= cur_next;
						run_q <= scan_res.run_next;
						if ((cur_next[5:0] == 6'd0) || (cur_next >= lim_pass_q)) begin
							state_q <= S_FETCH;
						end
					end
				end
				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end
				S_RMW_WR: begin
					if (row_q == hi_q[RAW+5:6]) begin
						state_q <= S_DONE;
					end else begin
						row_q   <= row_q + RAW'(1);
						state_q <= S_RMW_RD;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= status_q;
			m_tdata_q <= {7'd0, count_q, first_q};
		end
	end

`ifndef NO_ASSERTIONS
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && !in_fire |=> $stable(count_q))
		else $error("page count moved with no request");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (start_q <= cur_q) && (cur_q < lim_pass_q))
		else $error("search position outside its pass");

	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (cmd_q == bpra_pkg::CMD_ALLOC) && (status_q == bpra_pkg::ST_DONE)
		|-> (first_q != '0))
		else $error("page zero handed out");

	a_err_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (status_q != bpra_pkg::ST_DONE) |-> (first_q == '0))
		else $error("failed request returns a page");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the bitmap page run allocator.
`timescale 1ns / 1ps

module tb;

	localparam int PAGES = 65536;
	localparam logic [1:0] CMD_NOP = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] page_index;
		logic [16:0] page_count;
	} page_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] first_page;
		logic [16:0] in_use;
	} run_result_t;

	typedef struct {
		int unsigned first;
		int unsigned n;
	} live_run_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser = '0;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [1:0]  m_axis_tuser;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;

	bit          page_used [PAGES];
	int unsigned next_fit;
	int unsigned pages_used;
	int unsigned usable_limit;

	page_req_t   request_q [$];
	run_result_t pending_results [$];
	live_run_t   live_runs [$];
	page_req_t   offered;
	run_result_t want_res;

	int unsigned requests_queued;
	int unsigned requests_taken;
	int unsigned tx_gap;
	int unsigned tx_calm;
	int unsigned rx_stall;
	int unsigned rx_calm;
	int unsigned hold_asks;
	int unsigned hold_served;
	int unsigned fail_count;

	bitmap_page_run_allocator #(
		.PAGES(PAGES)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic void clear_pages(input int unsigned first, input int unsigned n);
		int unsigned i;
		for (i = 0; i < n; i++) begin
			if (first + i >= PAGES)
				break;
			page_used[first + i] = 1'b0;
		end
	endfunction

	function automatic bit claim_run(input int unsigned lim, input int unsigned n,
			output int unsigned first);
		int unsigned run;
		int unsigned p;
		int unsigned i;
		run = 0;
		first = 0;
		while (next_fit < lim) begin
			p = next_fit;
			next_fit++;
			if (p != 0 && !page_used[p]) begin
				run++;
				if (run == n) begin
					first = next_fit - n;
					for (i = first; i < next_fit; i++)
						page_used[i] = 1'b1;
					return 1'b1;
				end
			end else begin
				run = 0;
			end
		end
		return 1'b0;
	endfunction

	function automatic run_result_t apply_request(input page_req_t req);
		run_result_t res;
		int unsigned n;
		int unsigned lim;
		int unsigned old_ptr;
		int unsigned first;
		bit          ok;
		live_run_t   lr;
		res.status = bpra_pkg::ST_DONE;
		res.first_page = '0;
		n = req.page_count;
		case (req.command)
			bpra_pkg::CMD_ALLOC: begin
				if (n == 0) begin
					res.status = bpra_pkg::ST_ZERO;
				end else begin
					lim = (usable_limit < PAGES) ? usable_limit : PAGES;
					old_ptr = next_fit;
					ok = claim_run(lim, n, first);
					if (!ok) begin
						next_fit = 0;
						ok = claim_run((old_ptr < lim) ? old_ptr : lim, n, first);
					end
					if (ok) begin
						res.first_page = first[15:0];
						pages_used = (bpra_pkg::CNT_MAX - pages_used < n) ?
							bpra_pkg::CNT_MAX : pages_used + n;
						lr.first = first;
						lr.n = n;
						live_runs.push_back(lr);
					end else begin
						next_fit = old_ptr;
						res.status = bpra_pkg::ST_OOM;
					end
				end
			end
			bpra_pkg::CMD_FREE: begin
				if (req.page_index != 0) begin
					clear_pages(req.page_index, n);
					if (req.page_index < next_fit)
						next_fit = req.page_index;
					pages_used = (pages_used < n) ? 0 : pages_used - n;
				end
			end
			bpra_pkg::CMD_RELEASE: begin
				clear_pages(req.page_index, n);
			end
			default: begin
			end
		endcase
		res.in_use = pages_used[16:0];
		return res;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				pending_results.push_back(apply_request(offered));
				requests_taken++;
			end
			if (tx_gap != 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (request_q.size() != 0) begin
				offered = request_q.pop_front();
				s_axis_tuser <= offered.command;
				s_axis_tdata <= {7'd0, offered.page_count, offered.page_index};
				s_axis_tvalid <= 1'b1;
				tx_gap = pick_gap(tx_calm);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected: status %0d page %0d in use %0d",
						$time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[32:16]);
					fail_count++;
				end else begin
					want_res = pending_results.pop_front();
					if (m_axis_tuser !== want_res.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want_res.status, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[15:0] !== want_res.first_page) begin
						$display("%0t: first_page expected %0d, got %0d",
							$time, want_res.first_page, m_axis_tdata[15:0]);
						fail_count++;
					end
					if (m_axis_tdata[32:16] !== want_res.in_use) begin
						$display("%0t: pages_in_use expected %0d, got %0d",
							$time, want_res.in_use, m_axis_tdata[32:16]);
						fail_count++;
					end
				end
			end
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				rx_stall = 400;
			end else if (m_axis_tvalid && m_axis_tready && rx_stall == 0) begin
				rx_stall = pick_gap(rx_calm);
			end
			if (rx_stall != 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic queue_request(input logic [1:0] cmd, input logic [15:0] page,
			input logic [16:0] cnt);
		page_req_t req;
		while (request_q.size() >= 2)
			@(posedge clk);
		req.command = cmd;
		req.page_index = page;
		req.page_count = cnt;
		request_q.push_back(req);
		requests_queued++;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (requests_taken != requests_queued || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [16:0] value);
		wait_idle();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		usable_limit = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned limit, input int unsigned items,
			input int unsigned hold_at);
		int unsigned i;
		int unsigned r;
		int unsigned k;
		live_run_t   lr;
		write_limit(limit[16:0]);
		queue_request(bpra_pkg::CMD_RELEASE, 16'd0, limit[16:0]);
		for (i = 0; i < items; i++) begin
			if (i == hold_at)
				hold_asks++;
			r = $urandom_range(0, 99);
			if (r < 40) begin
				queue_request(bpra_pkg::CMD_ALLOC, 16'($urandom),
					($urandom_range(0, 9) == 0) ? 17'($urandom_range(1, 64)) :
					17'($urandom_range(1, 8)));
			end else if (r < 72 && live_runs.size() != 0) begin
				k = $urandom_range(0, live_runs.size() - 1);
				lr = live_runs[k];
				live_runs.delete(k);
				queue_request(bpra_pkg::CMD_FREE, lr.first[15:0], lr.n[16:0]);
			end else if (r < 80) begin
				queue_request(bpra_pkg::CMD_RELEASE,
					16'($urandom_range(0, (limit > 0) ? limit - 1 : 0)),
					17'($urandom_range(1, 32)));
			end else begin
				queue_request(2'($urandom_range(0, 3)), 16'($urandom),
					($urandom_range(0, 19) == 0) ? 17'($urandom_range(0, 65536)) :
					17'($urandom_range(0, 40)));
			end
		end
	endtask

	initial begin
		foreach (page_used[p])
			page_used[p] = 1'b1;
		next_fit = 0;
		pages_used = 0;
		usable_limit = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_limit(17'd0);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd0);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd1);
		queue_request(bpra_pkg::CMD_FREE, 16'd0, 17'd5);
		queue_request(CMD_NOP, 16'hFFFF, 17'd65536);
		queue_request(bpra_pkg::CMD_RELEASE, 16'd0, 17'd1);

		write_limit(17'd65536);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd1);
		queue_request(bpra_pkg::CMD_RELEASE, 16'd0, 17'd65536);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd65536);
		queue_request(bpra_pkg::CMD_ALLOC, 16'hFFFF, 17'd65535);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd1);
		queue_request(bpra_pkg::CMD_RELEASE, 16'd1, 17'd65535);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd65535);
		queue_request(bpra_pkg::CMD_RELEASE, 16'd1, 17'd65535);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd2);
		queue_request(bpra_pkg::CMD_FREE, 16'hFFFF, 17'd65536);
		queue_request(bpra_pkg::CMD_FREE, 16'd1, 17'd0);
		queue_request(bpra_pkg::CMD_FREE, 16'd3, 17'd65536);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd1);
		queue_request(bpra_pkg::CMD_RELEASE, 16'hFFFF, 17'd0);
		queue_request(bpra_pkg::CMD_ALLOC, 16'd0, 17'd16);

		random_phase(64, 120, 60);
		random_phase(1, 30, 1000);
		random_phase(2, 30, 1000);
		random_phase(65535, 20, 1000);
		random_phase($urandom_range(200, 1024), 140, 70);
		random_phase($urandom_range(200, 1024), 140, 1000);
		random_phase($urandom_range(200, 1024), 140, 1000);
		random_phase($urandom_range(200, 1024), 140, 1000);
		random_phase($urandom_range(200, 1024), 140, 1000);
		random_phase(65536, 20, 1000);
		random_phase($urandom_range(100, 600), 80, 1000);

		wait_idle();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
